### design/swcb_pkg.sv
`default_nettype none
package swcb_pkg;
   localparam int KEY_COUNT_DEF    = 16;
   localparam int WINDOW_DEPTH_DEF = 32;
   localparam int CFG_W            = 17;

   localparam logic [1:0] OP_ALLOW   = 2'd0;
   localparam logic [1:0] OP_SUCCESS = 2'd1;
   localparam logic [1:0] OP_FAILURE = 2'd2;

   localparam logic [1:0] MODE_CLOSED = 2'd0;
   localparam logic [1:0] MODE_OPEN   = 2'd1;
   localparam logic [1:0] MODE_HALF   = 2'd2;

   localparam logic [1:0] REG_WINDOW  = 2'd0;
   localparam logic [1:0] REG_MIN     = 2'd1;
   localparam logic [1:0] REG_RATE    = 2'd2;
   localparam logic [1:0] REG_TRIAL   = 2'd3;
endpackage
`default_nettype wire

### design/swcb_ram.sv
`default_nettype none
module swcb_ram #(
   parameter int WIDTH = 33,
   parameter int DEPTH = 512
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) mem[wr_addr] <= wr_data;
      rd_data <= mem[rd_addr];
   end
endmodule
`default_nettype wire

### design/sliding_window_circuit_breaker.sv
`default_nettype none
// Sliding-window circuit breaker with one breaker per key. A request first
// retires the stale events of its key's window. A failure then runs the
// ratio test over each bit of the event count, followed by a decision step.
// The event ring is one RAM with one read port, walked one event at a time
// from the oldest. The ratio test is one shared adder doing shift-and-add
// over the count bits. The block takes one request at a time. req_ready is
// high only while idle with no result waiting. There is no clearing pass:
// ring entries are only read inside their live span.
module sliding_window_circuit_breaker
   import swcb_pkg::*;
#(
   parameter int KEY_COUNT    = KEY_COUNT_DEF,
   parameter int WINDOW_DEPTH = WINDOW_DEPTH_DEF
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output logic                  req_ready,
   input  wire logic [1:0]       req_operation,
   input  wire logic [3:0]       req_key_index,
   input  wire logic [31:0]      req_now,
   output logic                  rsp_valid,
   input  wire logic             rsp_ready,
   output logic                  rsp_allowed,
   output logic [1:0]            rsp_breaker_mode,
   output logic [5:0]            rsp_events_in_window,
   output logic [5:0]            rsp_failures_in_window,
   input  wire logic             csr_write_enable,
   input  wire logic [1:0]       csr_index,
   input  wire logic [CFG_W-1:0] csr_write_data
);
   localparam int KW = (KEY_COUNT > 1) ? $clog2(KEY_COUNT) : 1;
   localparam int HW = $clog2(WINDOW_DEPTH);
   localparam int CW = $clog2(WINDOW_DEPTH + 1);
   localparam int AW = KW + HW;
   localparam int PW = CW + 17;
   localparam int BW = (CW > 1) ? $clog2(CW) : 1;
   localparam logic [CW-1:0] DEPTH_C = CW'(WINDOW_DEPTH);

   typedef enum logic [2:0] {
      ST_IDLE, ST_READ, ST_CHECK, ST_ACT, ST_MULT, ST_DECIDE, ST_DONE
   } state_type;

   function automatic logic [HW-1:0] head_inc(input logic [HW-1:0] h);
      return (h == HW'(WINDOW_DEPTH - 1)) ? '0 : HW'(h + HW'(1));
   endfunction

   state_type      state_ff;
   logic [15:0]    window_ff;
   logic [5:0]     min_ff;
   logic [16:0]    rate_ff;
   logic [7:0]     trial_lim_ff;

   logic [1:0]     mode_ff   [KEY_COUNT];
   logic [31:0]    dead_ff   [KEY_COUNT];
   logic [7:0]     trial_ff  [KEY_COUNT];
   logic [HW-1:0]  head_ff   [KEY_COUNT];
   logic [CW-1:0]  count_ff  [KEY_COUNT];
   logic [CW-1:0]  fails_ff  [KEY_COUNT];

   logic [1:0]     op_ff;
   logic [KW-1:0]  key_ff;
   logic [31:0]    now_ff;
   // shift-and-add: rate * count accumulated one bit per cycle
   logic [PW-1:0]  prod_ff;
   logic [BW-1:0]  bit_ff;

   logic           wr_en;
   logic [AW-1:0]  wr_addr, rd_addr;
   logic [32:0]    rd_data;

   logic [KW-1:0]  key_in;
   logic [HW-1:0]  head_k, push_pos;
   logic [CW-1:0]  cnt_k, fl_k;
   logic [CW:0]    pos_sum;
   logic [31:0]    age;
   logic           rd_fail;

   // key index folded modulo the key count over its sixteen values
   always_comb begin
      key_in = '0;
      for (int v = 0; v < 16; v++)
         if (req_key_index == 4'(v)) key_in = KW'(v % KEY_COUNT);
   end

   assign head_k   = head_ff[key_ff];
   assign cnt_k    = count_ff[key_ff];
   assign fl_k     = fails_ff[key_ff];
   assign rd_addr  = {key_ff, head_k};
   assign age      = now_ff - rd_data[31:0];
   assign rd_fail  = rd_data[32];
   // slot after the newest event; a full ring reuses the oldest slot
   assign pos_sum  = (CW+1)'(head_k) + (CW+1)'(cnt_k);
   assign push_pos = (pos_sum >= (CW+1)'(WINDOW_DEPTH)) ?
                     HW'(pos_sum - (CW+1)'(WINDOW_DEPTH)) : HW'(pos_sum);
   assign wr_en    = (state_ff == ST_ACT) && (op_ff == OP_SUCCESS || op_ff == OP_FAILURE);
   assign wr_addr  = {key_ff, push_pos};

   swcb_ram #(.WIDTH(33), .DEPTH(2 ** AW)) u_ring (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data ({op_ff == OP_FAILURE, now_ff}),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign req_ready = (state_ff == ST_IDLE) && !rsp_valid;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid    <= 1'b0;
         window_ff    <= 16'd60;
         min_ff       <= 6'd10;
         rate_ff      <= 17'd32768;
         trial_lim_ff <= 8'd1;
         for (int i = 0; i < KEY_COUNT; i++) begin
            mode_ff[i]  <= MODE_CLOSED;
            dead_ff[i]  <= '0;
            trial_ff[i] <= '0;
            head_ff[i]  <= '0;
            count_ff[i] <= '0;
            fails_ff[i] <= '0;
         end
      end else begin
         if (csr_write_enable) begin
            unique case (csr_index)
               REG_WINDOW: window_ff    <= csr_write_data[15:0];
               REG_MIN:    min_ff       <= csr_write_data[5:0];
               REG_RATE:   rate_ff      <= csr_write_data[16:0];
               REG_TRIAL:  trial_lim_ff <= csr_write_data[7:0];
               default: ;
            endcase
         end
         if (rsp_valid && rsp_ready) rsp_valid <= 1'b0;
         unique case (state_ff)
            ST_IDLE: if (req_valid && req_ready) begin
               op_ff       <= req_operation;
               key_ff      <= key_in;
               now_ff      <= req_now;
               rsp_allowed <= 1'b0;
               state_ff    <= ST_READ;
            end
            ST_READ: state_ff <= ST_CHECK;
            ST_CHECK: begin
               if (cnt_k != '0 && age > {16'd0, window_ff}) begin
                  if (rd_fail && fl_k != '0) fails_ff[key_ff] <= CW'(fl_k - 1'b1);
                  head_ff[key_ff]  <= head_inc(head_k);
                  count_ff[key_ff] <= CW'(cnt_k - 1'b1);
                  state_ff         <= ST_READ;
               end else begin
                  state_ff <= ST_ACT;
               end
            end
            ST_ACT: begin
               state_ff <= ST_DONE;
               unique case (op_ff)
                  OP_ALLOW: begin
                     if (mode_ff[key_ff] == MODE_OPEN) begin
                        if ((now_ff - dead_ff[key_ff]) < 32'h8000_0000) begin
                           if (trial_lim_ff != 8'd0) begin
                              mode_ff[key_ff]  <= MODE_HALF;
                              trial_ff[key_ff] <= 8'd1;
                              rsp_allowed      <= 1'b1;
                           end else begin
                              mode_ff[key_ff]  <= MODE_HALF;
                              trial_ff[key_ff] <= 8'd0;
                           end
                        end
                     end else if (mode_ff[key_ff] == MODE_HALF) begin
                        if (trial_ff[key_ff] < trial_lim_ff) begin
                           trial_ff[key_ff] <= trial_ff[key_ff] + 8'd1;
                           rsp_allowed      <= 1'b1;
                        end
                     end else begin
                        rsp_allowed <= 1'b1;
                     end
                  end
                  OP_SUCCESS: begin
                     if (mode_ff[key_ff] == MODE_HALF && trial_ff[key_ff] >= trial_lim_ff)
                     begin
                        mode_ff[key_ff]  <= MODE_CLOSED;
                        count_ff[key_ff] <= '0;
                        head_ff[key_ff]  <= '0;
                        fails_ff[key_ff] <= '0;
                        trial_ff[key_ff] <= '0;
                     end else if (cnt_k >= DEPTH_C) begin
                        if (rd_fail && fl_k != '0) fails_ff[key_ff] <= CW'(fl_k - 1'b1);
                        head_ff[key_ff] <= head_inc(head_k);
                     end else begin
                        count_ff[key_ff] <= CW'(cnt_k + 1'b1);
                     end
                  end
                  OP_FAILURE: begin
                     if (cnt_k >= DEPTH_C) begin
                        head_ff[key_ff] <= head_inc(head_k);
                        fails_ff[key_ff] <= CW'(fl_k - CW'(rd_fail && fl_k != '0) + 1'b1);
                     end else begin
                        count_ff[key_ff] <= CW'(cnt_k + 1'b1);
                        fails_ff[key_ff] <= CW'(fl_k + 1'b1);
                     end
                     prod_ff  <= '0;
                     bit_ff   <= BW'(CW - 1);
                     state_ff <= ST_MULT;
                  end
                  default: ;
               endcase
            end
            ST_MULT: begin
               prod_ff <= {prod_ff[PW-2:0], 1'b0} + (cnt_k[bit_ff] ? PW'(rate_ff) : '0);
               bit_ff  <= bit_ff - BW'(1);
               if (bit_ff == '0) state_ff <= ST_DECIDE;
            end
            ST_DECIDE: begin
               state_ff <= ST_DONE;
               if ((32'(cnt_k) >= 32'(min_ff) && {1'b0, fl_k, 16'd0} >= prod_ff) ||
                   mode_ff[key_ff] == MODE_HALF) begin
                  mode_ff[key_ff]  <= MODE_OPEN;
                  dead_ff[key_ff]  <= now_ff + {16'd0, window_ff};
                  trial_ff[key_ff] <= '0;
               end
            end
            ST_DONE: begin
               rsp_breaker_mode       <= mode_ff[key_ff];
               rsp_events_in_window   <= 6'(cnt_k);
               rsp_failures_in_window <= 6'(fl_k);
               rsp_valid              <= 1'b1;
               state_ff               <= ST_IDLE;
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end
endmodule
`default_nettype wire

### design/swcb_checker.sv
`default_nettype none
module swcb_checker
   import swcb_pkg::*;
(
   input wire logic       clock,
   input wire logic       reset,
   input wire logic       req_valid,
   input wire logic       req_ready,
   input wire logic       rsp_valid,
   input wire logic       rsp_ready,
   input wire logic       rsp_allowed,
   input wire logic [1:0] rsp_breaker_mode,
   input wire logic [5:0] rsp_events_in_window,
   input wire logic [5:0] rsp_failures_in_window
);
   a_fail_le_events: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_failures_in_window <= rsp_events_in_window)
      else $error("failures exceed events");
   a_no_accept_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !req_ready)
      else $error("request taken while result waits");
   a_open_denies: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_breaker_mode == MODE_OPEN |-> !rsp_allowed)
      else $error("open breaker granted");
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_breaker_mode))
      else $error("result dropped");
   a_req_hold: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_ready |=> req_valid)
      else $error("request withdrawn");
endmodule

bind sliding_window_circuit_breaker swcb_checker u_swcb_checker (
   .clock(clock), .reset(reset), .req_valid(req_valid), .req_ready(req_ready),
   .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_allowed(rsp_allowed),
   .rsp_breaker_mode(rsp_breaker_mode), .rsp_events_in_window(rsp_events_in_window),
   .rsp_failures_in_window(rsp_failures_in_window)
);
`default_nettype wire

### verif/tb.sv
`timescale 1ns / 100ps
module tb
   import swcb_pkg::*;
();

   typedef struct packed {
      logic [1:0]  op;
      logic [3:0]  key;
      logic [31:0] now;
   } breaker_req_t;

   typedef struct packed {
      logic       allowed;
      logic [1:0] mode;
      logic [5:0] events;
      logic [5:0] fails;
   } breaker_rsp_t;

   localparam int DEPTH = 32;
   localparam int KEYS  = 16;
   localparam logic [1:0] OP_UNUSED = 2'd3;

   logic clock = 0;
   logic reset = 1;
   logic req_valid = 0;
   logic req_ready;
   logic [1:0] req_operation = '0;
   logic [3:0] req_key_index = '0;
   logic [31:0] req_now = '0;
   logic rsp_valid;
   logic rsp_ready = 0;
   logic rsp_allowed;
   logic [1:0] rsp_breaker_mode;
   logic [5:0] rsp_events_in_window, rsp_failures_in_window;
   logic csr_write_enable = 0;
   logic [1:0] csr_index = '0;
   logic [CFG_W-1:0] csr_write_data = '0;

   sliding_window_circuit_breaker dut (.*);

   always #6 clock = ~clock;

   // breaker state as predicted
   logic [15:0] cfg_window;
   logic [5:0]  cfg_min;
   logic [16:0] cfg_rate;
   logic [7:0]  cfg_trials;
   logic [1:0]  mode_q [KEYS];
   logic [31:0] deadline_q [KEYS];
   logic [7:0]  trials_q [KEYS];
   logic [4:0]  head_q [KEYS];
   logic [5:0]  count_q [KEYS];
   logic [5:0]  fails_q [KEYS];
   logic [31:0] ev_time [KEYS][DEPTH];
   logic        ev_fail [KEYS][DEPTH];

   breaker_req_t pending_reqs[$];
   breaker_rsp_t expected_rsps[$];
   int mismatches = 0;
   int sender_idle_pct = 0, receiver_idle_pct = 0;
   int hold_off = 0;
   int stall_asked = 0, stall_served = 0;
   bit done = 0;
   longint cycles = 0;

   function automatic void drop_oldest(int k);
      if (count_q[k] == 0) return;
      if (ev_fail[k][head_q[k]] && fails_q[k] > 0) fails_q[k]--;
      head_q[k]++;
      count_q[k]--;
   endfunction

   function automatic void push_event(int k, logic [31:0] now, bit f);
      logic [4:0] pos;
      if (count_q[k] >= DEPTH) drop_oldest(k);
      pos = head_q[k] + count_q[k][4:0];
      ev_time[k][pos] = now;
      ev_fail[k][pos] = f;
      count_q[k]++;
      if (f) fails_q[k]++;
   endfunction

   function automatic void trip(int k, logic [31:0] now);
      mode_q[k] = MODE_OPEN;
      deadline_q[k] = now + {16'd0, cfg_window};
      trials_q[k] = 0;
   endfunction

   function automatic breaker_rsp_t predict_breaker(breaker_req_t r);
      breaker_rsp_t res;
      int k;
      bit go;
      logic [31:0] age;
      logic [63:0] lhs, rhs;
      k = r.key;
      go = 0;
      while (count_q[k] > 0) begin
         age = r.now - ev_time[k][head_q[k]];
         if (age <= {16'd0, cfg_window}) break;
         drop_oldest(k);
      end
      case (r.op)
         OP_ALLOW: begin
            go = 1;
            if (mode_q[k] == MODE_OPEN) begin
               if ((r.now - deadline_q[k]) < 32'h8000_0000) begin
                  mode_q[k] = MODE_HALF;
                  trials_q[k] = 0;
               end else go = 0;
            end
            if (go && mode_q[k] == MODE_HALF) begin
               if (trials_q[k] >= cfg_trials) go = 0;
               else trials_q[k]++;
            end
         end
         OP_SUCCESS: begin
            push_event(k, r.now, 0);
            if (mode_q[k] == MODE_HALF && trials_q[k] >= cfg_trials) begin
               mode_q[k] = MODE_CLOSED;
               count_q[k] = 0;
               head_q[k] = 0;
               fails_q[k] = 0;
               trials_q[k] = 0;
            end
         end
         OP_FAILURE: begin
            push_event(k, r.now, 1);
            lhs = 64'(fails_q[k]) * 65536;
            rhs = 64'(cfg_rate) * 64'(count_q[k]);
            if (count_q[k] >= cfg_min && lhs >= rhs) trip(k, r.now);
            if (mode_q[k] == MODE_HALF) trip(k, r.now);
         end
         default: ;
      endcase
      res.allowed = go;
      res.mode = mode_q[k];
      res.events = count_q[k];
      res.fails = fails_q[k];
      return res;
   endfunction

   // driver
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && req_ready) begin
            expected_rsps.insert(expected_rsps.size(), predict_breaker(
               breaker_req_t'{req_operation, req_key_index, req_now}));
            void'(pending_reqs.pop_front());
         end
         if ((!req_valid || req_ready) && pending_reqs.size() > 0 &&
             !(req_valid && req_ready && pending_reqs.size() == 1) &&
             $urandom_range(99) >= sender_idle_pct) begin
            breaker_req_t n;
            n = (req_valid && req_ready) ? pending_reqs[0] : pending_reqs[0];
            req_valid <= 1;
            req_operation <= n.op;
            req_key_index <= n.key;
            req_now <= n.now;
         end else if (!req_valid || req_ready) begin
            req_valid <= 0;
         end
      end
   end

   // receiver hold-off counter
   always @(posedge clock) begin
      if (stall_served != stall_asked) begin
         stall_served <= stall_asked;
         hold_off <= 400;
      end else if (hold_off > 0) begin
         hold_off <= hold_off - 1;
      end
   end

   // monitor
   always @(posedge clock) begin
      cycles++;
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            if (expected_rsps.size() == 0) begin
               mismatches++;
               if (mismatches <= 10) $display("unexpected result");
            end else begin
               breaker_rsp_t e;
               e = expected_rsps.pop_front();
               if (e !== {rsp_allowed, rsp_breaker_mode, rsp_events_in_window,
                          rsp_failures_in_window}) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display("mismatch: exp %b/%0d/%0d/%0d got %b/%0d/%0d/%0d",
                        e.allowed, e.mode, e.events, e.fails, rsp_allowed,
                        rsp_breaker_mode, rsp_events_in_window, rsp_failures_in_window);
               end
            end
         end
         if (hold_off > 0) rsp_ready <= 0;
         else rsp_ready <= $urandom_range(99) >= receiver_idle_pct;
      end
      if (cycles > 2000000 && !done) begin
         $display("tb NOT OK");
         $finish;
      end
   end

   task automatic write_reg(logic [1:0] idx, logic [CFG_W-1:0] val);
      @(posedge clock);
      csr_write_enable <= 1;
      csr_index <= idx;
      csr_write_data <= val;
      @(posedge clock);
      csr_write_enable <= 0;
      case (idx)
         REG_WINDOW: cfg_window = val[15:0];
         REG_MIN:    cfg_min = val[5:0];
         REG_RATE:   cfg_rate = val;
         default:    cfg_trials = val[7:0];
      endcase
   endtask

   task automatic drain();
      while (pending_reqs.size() > 0 || expected_rsps.size() > 0 || req_valid)
         @(posedge clock);
      repeat (80) @(posedge clock);
   endtask

   logic [31:0] clk_now;

   task automatic add_req(logic [1:0] op, logic [3:0] key, logic [31:0] step);
      clk_now += step;
      pending_reqs.insert(pending_reqs.size(), breaker_req_t'{op, key, clk_now});
   endtask

   // mostly well-formed traffic on a few hot keys, some noise
   task automatic random_phase(int n);
      int op, key;
      for (int i = 0; i < n; i++) begin
         op = $urandom_range(99);
         op = op < 40 ? OP_ALLOW : op < 65 ? OP_SUCCESS : op < 97 ? OP_FAILURE : OP_UNUSED;
         key = ($urandom_range(3) == 0) ? $urandom_range(15) : $urandom_range(2);
         if ($urandom_range(49) == 0)
            clk_now = $urandom;
         else if ($urandom_range(29) == 0)
            clk_now -= $urandom_range(200);
         add_req(2'(op), 4'(key),
                 $urandom_range(3) == 0 ? $urandom_range(90) : $urandom_range(4));
      end
   endtask

   initial begin
      cfg_window = 60; cfg_min = 10; cfg_rate = 32768; cfg_trials = 1;
      for (int k = 0; k < KEYS; k++) begin
         mode_q[k] = MODE_CLOSED; deadline_q[k] = 0; trials_q[k] = 0;
         head_q[k] = 0; count_q[k] = 0; fails_q[k] = 0;
      end
      clk_now = 32'hFFFF_FF00;
      repeat (8) @(posedge clock);
      reset <= 0;
      sender_idle_pct = 19; receiver_idle_pct = 79;
      write_reg(REG_MIN, 2);
      write_reg(REG_TRIAL, 2);
      // directed: open, half-open trials, close, reopen, time wrap, op 3, full ring
      for (int i = 0; i < 3; i++) add_req(OP_FAILURE, 4'd15, 1);
      add_req(OP_ALLOW, 4'd15, 1);
      add_req(OP_ALLOW, 4'd15, 70);
      add_req(OP_ALLOW, 4'd15, 0);
      add_req(OP_ALLOW, 4'd15, 0);
      add_req(OP_SUCCESS, 4'd15, 1);
      add_req(OP_FAILURE, 4'd15, 1);
      add_req(OP_FAILURE, 4'd15, 1);
      add_req(OP_UNUSED, 4'd15, 200);
      add_req(OP_SUCCESS, 4'd0, 0);
      add_req(OP_FAILURE, 4'd0, 32'h7FFF_FFFF);
      add_req(OP_ALLOW, 4'd0, 32'h8000_0000);
      for (int i = 0; i < 36; i++) add_req(OP_SUCCESS, 4'd5, 0);
      add_req(OP_FAILURE, 4'd5, 0);
      add_req(OP_ALLOW, 4'd10, 1);
      clk_now -= 300;
      add_req(OP_ALLOW, 4'd15, 0);
      drain();
      random_phase(300);
      // long receiver stall while requests keep coming
      stall_asked++;
      drain();
      write_reg(REG_WINDOW, 0);
      write_reg(REG_MIN, 0);
      write_reg(REG_RATE, 0);
      write_reg(REG_TRIAL, 0);
      random_phase(150);
      drain();
      sender_idle_pct = 79; receiver_idle_pct = 19;
      write_reg(REG_WINDOW, 16'hFFFF);
      write_reg(REG_MIN, 63);
      write_reg(REG_RATE, 17'h1FFFF);
      write_reg(REG_TRIAL, 255);
      random_phase(200);
      drain();
      write_reg(REG_WINDOW, 40);
      write_reg(REG_MIN, 32);
      write_reg(REG_RATE, 65536);
      write_reg(REG_TRIAL, 3);
      random_phase(200);
      drain();
      sender_idle_pct = 0; receiver_idle_pct = 0;
      write_reg(REG_WINDOW, 25);
      write_reg(REG_MIN, 4);
      write_reg(REG_RATE, 20000);
      write_reg(REG_TRIAL, 1);
      random_phase(400);
      drain();
      done = 1;
      if (mismatches == 0 && expected_rsps.size() == 0) $display("tb OK");
      else $display("tb NOT OK");
      $finish;
   end
endmodule
